// ----- hw/rtl/bse_pkg.sv -----
// ----------------------------------------------------------------------------
// bse_pkg
// Shared constants, operation codes and helpers for the bitmap set engine.
// ----------------------------------------------------------------------------
package bse_pkg;

  localparam int BITS   = 256;
  localparam int NBYTES = (BITS + 7) / 8;
  localparam int ADDR_W = $clog2(NBYTES);
  localparam int IDX_W  = 8;
  localparam int LEN_W  = 9;
  localparam int KIND_W = 3;

  localparam logic [LEN_W-1:0] BITS_LEN = LEN_W'(BITS);

  localparam logic [KIND_W-1:0] OP_CLEAR_ALL = 3'd0;
  localparam logic [KIND_W-1:0] OP_SET       = 3'd1;
  localparam logic [KIND_W-1:0] OP_SET_MASK  = 3'd2;
  localparam logic [KIND_W-1:0] OP_CLEAR     = 3'd3;
  localparam logic [KIND_W-1:0] OP_TEST      = 3'd4;
  localparam logic [KIND_W-1:0] OP_COUNT     = 3'd5;
  localparam logic [KIND_W-1:0] OP_FIND      = 3'd6;

  localparam logic [3:0] NIB_POP [16] = '{
    4'd0, 4'd1, 4'd1, 4'd2, 4'd1, 4'd2, 4'd2, 4'd3,
    4'd1, 4'd2, 4'd2, 4'd3, 4'd2, 4'd3, 4'd3, 4'd4
  };

  // population count of one byte from two nibble lookups
  function automatic logic [3:0] byte_pop(input logic [7:0] v);
    byte_pop = NIB_POP[v[3:0]] + NIB_POP[v[7:4]];
  endfunction

endpackage

// ----- hw/rtl/bitmap_set_engine_unit.sv -----
// ----------------------------------------------------------------------------
// bitmap_set_engine_unit
// Bitmap held as bytes in a synchronous memory; set, clear, test, count and
// find-next-set operations by read-modify-write and byte walks.
// ----------------------------------------------------------------------------
//  channel | signals                       | dir | payload
//  --------+-------------------------------+-----+------------------------------
//  in      | in_valid / in_stall           | in  | kind, index, mask_bit
//  out     | out_valid / out_stall         | out | bit_value, set_count, is_empty,
//          |                               |     | found, found_index
//  cfg     | cfg_valid / cfg_ready         | in  | cfg_data (active_bits)
//
// set, set masked, clear, test, clear all: one memory read, then a write back for set,
// clear and set masked with mask_bit high. count: walks the bytes below active_bits.
// find: walks from the start byte to the first set bit or the end of active_bits.
// one byte per cycle through the single memory read port sets the walk length.
// reset and clear all empty the bitmap by clearing the per-byte valid flags.
// a stalled output holds the engine in its last step; the next beat is taken
// once the result moves into the output register.
module bitmap_set_engine_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [bse_pkg::KIND_W-1:0]   kind,
  input  logic [bse_pkg::IDX_W-1:0]    index,
  input  logic                         mask_bit,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         bit_value,
  output logic [bse_pkg::LEN_W-1:0]    set_count,
  output logic                         is_empty,
  output logic                         found,
  output logic [bse_pkg::LEN_W-1:0]    found_index,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bse_pkg::LEN_W-1:0]    cfg_data
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                          state;
  logic [bse_pkg::KIND_W-1:0]    op;
  logic [bse_pkg::IDX_W-1:0]     idx;
  logic                          mbit;
  logic [bse_pkg::ADDR_W-1:0]    cur;
  logic                          first;
  logic [bse_pkg::LEN_W-1:0]     acc;
  logic [bse_pkg::LEN_W-1:0]     active_bits;
  logic [bse_pkg::NBYTES-1:0]    vld;

  logic [7:0]                    mem [bse_pkg::NBYTES];
  logic [7:0]                    rdata;
  logic [bse_pkg::ADDR_W-1:0]    raddr;

  logic                          in_accept;
  logic                          out_free;
  logic [bse_pkg::LEN_W-1:0]     len;
  logic [7:0]                    cur_byte;
  logic [bse_pkg::LEN_W-1:0]     base;
  logic [bse_pkg::LEN_W-1:0]     next_base;
  logic [bse_pkg::LEN_W-1:0]     rem;
  logic [7:0]                    len_mask;
  logic [7:0]                    start_mask;
  logic [7:0]                    v_range;
  logic [7:0]                    v_find;
  logic [2:0]                    low_pos;
  logic                          walk_end;
  logic                          simple_op;
  logic                          is_write;
  logic                          last;
  logic                          done;
  logic [7:0]                    bit_sel;
  logic [7:0]                    wdata;
  logic [bse_pkg::LEN_W-1:0]     cnt_total;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);
  assign out_free  = !out_valid || !out_stall;

  assign len = (active_bits > bse_pkg::BITS_LEN) ? bse_pkg::BITS_LEN : active_bits;

  // bytes not written since reset or clear all read as zero
  assign cur_byte = vld[cur] ? rdata : 8'h00;

  assign base      = {1'b0, cur, 3'b000};
  assign next_base = base + bse_pkg::LEN_W'(8);
  assign rem       = len - base;
  assign walk_end  = (next_base >= len);

  always_comb begin
    if (base >= len) begin
      len_mask = 8'h00;
    end else if (rem < bse_pkg::LEN_W'(8)) begin
      len_mask = (8'h01 << rem[2:0]) - 8'h01;
    end else begin
      len_mask = 8'hff;
    end
  end

  assign start_mask = first ? (8'hff << idx[2:0]) : 8'hff;
  assign v_range    = cur_byte & len_mask;
  assign v_find     = v_range & start_mask;

  always_comb begin
    low_pos = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (v_find[i]) begin
        low_pos = 3'(i);
      end
    end
  end

  assign simple_op = (op != bse_pkg::OP_COUNT) && (op != bse_pkg::OP_FIND);
  assign is_write  = (op == bse_pkg::OP_SET) || (op == bse_pkg::OP_CLEAR) ||
                     ((op == bse_pkg::OP_SET_MASK) && mbit);

  always_comb begin
    case (op)
      bse_pkg::OP_COUNT: last = walk_end;
      bse_pkg::OP_FIND:  last = walk_end || (v_find != 8'h00);
      default:           last = simple_op;
    endcase
  end

  assign done = (state == ST_RUN) && last && out_free;

  assign bit_sel = 8'h01 << idx[2:0];
  assign wdata   = (op == bse_pkg::OP_CLEAR) ? (cur_byte & ~bit_sel) : (cur_byte | bit_sel);

  assign cnt_total = acc + bse_pkg::LEN_W'(bse_pkg::byte_pop(v_range));

  // read address: start byte on accept, next byte while walking, else hold
  always_comb begin
    if (state == ST_IDLE) begin
      raddr = (kind == bse_pkg::OP_COUNT) ? '0 : index[bse_pkg::IDX_W-1:3];
    end else if (!last) begin
      raddr = cur + bse_pkg::ADDR_W'(1);
    end else begin
      raddr = cur;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (done && is_write) begin
      mem[cur] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      vld         <= '0;
      active_bits <= bse_pkg::BITS_LEN;
      out_valid   <= 1'b0;
      acc         <= '0;
      first       <= 1'b0;
      cur         <= '0;
    end else begin
      cur <= raddr;
      if (cfg_valid && cfg_ready) begin
        active_bits <= cfg_data;
      end
      if (in_accept) begin
        state <= ST_RUN;
        first <= 1'b1;
        acc   <= '0;
      end else if (state == ST_RUN) begin
        if (!last) begin
          first <= 1'b0;
          acc   <= cnt_total;
        end else if (out_free) begin
          state <= ST_IDLE;
        end
      end
      if (done && is_write) begin
        vld[cur] <= 1'b1;
      end
      if (done && (op == bse_pkg::OP_CLEAR_ALL)) begin
        vld <= '0;
      end
      if (done) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // beat capture, payload only
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op   <= kind;
      idx  <= index;
      mbit <= mask_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      bit_value   <= (op == bse_pkg::OP_TEST) ? cur_byte[idx[2:0]] : 1'b0;
      set_count   <= (op == bse_pkg::OP_COUNT) ? cnt_total : '0;
      is_empty    <= (op == bse_pkg::OP_COUNT) && (cnt_total == '0);
      found       <= (op == bse_pkg::OP_FIND) && (v_find != 8'h00);
      if (op == bse_pkg::OP_FIND) begin
        found_index <= (v_find != 8'h00) ? {1'b0, cur, low_pos} : len;
      end else begin
        found_index <= '0;
      end
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> in_stall)
    else $error("engine took a beat without going busy");

  a_empty_means_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_empty) |-> (set_count == '0))
    else $error("empty flag with nonzero count");

  a_found_in_map: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found) |-> (found_index < bse_pkg::BITS_LEN))
    else $error("found index outside the bitmap");

endmodule
